// ----- rtl/sfp_pkg.sv -----
package sfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned SUM_W    = 16;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned REG_IDX_W = 1;

    // frame layout: bytes 0..8 are header and control, payload starts at 9
    localparam logic [POS_W-1:0] POS_HDR1     = 9'd0;
    localparam logic [POS_W-1:0] POS_HDR2     = 9'd1;
    localparam logic [POS_W-1:0] POS_SRC_HI   = 9'd2;
    localparam logic [POS_W-1:0] POS_SRC_LO   = 9'd3;
    localparam logic [POS_W-1:0] POS_DST_HI   = 9'd4;
    localparam logic [POS_W-1:0] POS_DST_LO   = 9'd5;
    localparam logic [POS_W-1:0] POS_CTRL     = 9'd6;
    localparam logic [POS_W-1:0] POS_FUNC     = 9'd7;
    localparam logic [POS_W-1:0] POS_LEN      = 9'd8;
    localparam logic [POS_W-1:0] POS_PAYLOAD  = 9'd9;
    localparam logic [POS_W-1:0] FRAME_OVERHEAD = 9'd11;

    localparam logic [REG_IDX_W-1:0] REG_HEADER_FIRST  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HEADER_SECOND = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_OK      = 2'd1,
        KIND_BAD_HDR = 2'd2,
        KIND_BAD_CKS = 2'd3
    } result_kind_t;

    typedef enum logic [3:0] {
        OP_HDR1,
        OP_HDR2,
        OP_BAD_HDR,
        OP_SRC_HI,
        OP_SRC_LO,
        OP_DST_HI,
        OP_DST_LO,
        OP_CTRL,
        OP_FUNC,
        OP_LEN,
        OP_PAYLOAD,
        OP_CKS_HI,
        OP_CKS_LO
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] index;   // payload position for OP_PAYLOAD
    } cmd_t;

endpackage

// ----- rtl/sfp_front.sv -----
module sfp_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [sfp_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [sfp_pkg::BYTE_W-1:0]  cfg_wdata,
    input  logic                        s_valid,
    input  logic                        q_ready,
    input  logic [sfp_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                        push,
    output sfp_pkg::cmd_t               cmd
);
    import sfp_pkg::*;

    logic [BYTE_W-1:0] hdr_first_reg;
    logic [BYTE_W-1:0] hdr_second_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              match_reg, match_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [POS_W-1:0]  cks_pos;
    logic [POS_W-1:0]  pay_index;

    assign push      = s_valid & q_ready;
    assign cks_pos   = POS_PAYLOAD + {1'b0, len_reg};
    assign pay_index = pos_reg - POS_PAYLOAD;

    always_comb begin
        pos_next   = pos_reg + 9'd1;
        match_next = match_reg;
        len_next   = len_reg;
        cmd.data   = s_rx_byte;
        cmd.index  = '0;
        cmd.op     = OP_CKS_LO;
        priority if (pos_reg == POS_HDR1) begin
            cmd.op     = OP_HDR1;
            match_next = (s_rx_byte == hdr_first_reg);
        end else if (pos_reg == POS_HDR2) begin
            if (!match_reg || s_rx_byte != hdr_second_reg) begin
                cmd.op     = OP_BAD_HDR;
                pos_next   = POS_HDR1;
                match_next = 1'b0;
            end else begin
                cmd.op = OP_HDR2;
            end
        end else if (pos_reg == POS_SRC_HI) begin
            cmd.op = OP_SRC_HI;
        end else if (pos_reg == POS_SRC_LO) begin
            cmd.op = OP_SRC_LO;
        end else if (pos_reg == POS_DST_HI) begin
            cmd.op = OP_DST_HI;
        end else if (pos_reg == POS_DST_LO) begin
            cmd.op = OP_DST_LO;
        end else if (pos_reg == POS_CTRL) begin
            cmd.op = OP_CTRL;
        end else if (pos_reg == POS_FUNC) begin
            cmd.op = OP_FUNC;
        end else if (pos_reg == POS_LEN) begin
            cmd.op   = OP_LEN;
            len_next = s_rx_byte;
        end else if (pos_reg < cks_pos) begin
            cmd.op    = OP_PAYLOAD;
            cmd.index = pay_index[BYTE_W-1:0];
        end else if (pos_reg == cks_pos) begin
            cmd.op = OP_CKS_HI;
        end else begin
            cmd.op     = OP_CKS_LO;
            pos_next   = POS_HDR1;
            match_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_first_reg  <= '0;
            hdr_second_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HEADER_FIRST:  hdr_first_reg  <= cfg_wdata;
                REG_HEADER_SECOND: hdr_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_HDR1;
            match_reg <= 1'b0;
            len_reg   <= '0;
        end else if (push) begin
            pos_reg   <= pos_next;
            match_reg <= match_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ----- rtl/sfp_queue.sv -----
module sfp_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sfp_pkg::cmd_t push_cmd,
    output logic          q_ready,
    input  logic          pop,
    output logic          q_valid,
    output sfp_pkg::cmd_t head_cmd
);
    import sfp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_ready  = (count_reg != FULL_COUNT);
    assign q_valid  = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

// ----- rtl/sfp_back.sv -----
module sfp_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  sfp_pkg::cmd_t              head_cmd,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_result_kind,
    output logic [sfp_pkg::BYTE_W-1:0] m_payload_byte,
    output logic [sfp_pkg::BYTE_W-1:0] m_payload_index,
    output logic [sfp_pkg::ADDR_W-1:0] m_source_address,
    output logic [sfp_pkg::ADDR_W-1:0] m_destination_address,
    output logic [sfp_pkg::BYTE_W-1:0] m_control_code,
    output logic [sfp_pkg::BYTE_W-1:0] m_function_code,
    output logic [sfp_pkg::BYTE_W-1:0] m_payload_length,
    output logic [sfp_pkg::POS_W-1:0]  m_frame_length,
    output logic                       m_end_of_frame
);
    import sfp_pkg::*;

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [BYTE_W-1:0] ctrl_reg, ctrl_next;
    logic [BYTE_W-1:0] func_reg, func_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] cks_hi_reg, cks_hi_next;
    logic [SUM_W-1:0]  sum_add;
    logic [SUM_W-1:0]  received;

    logic              out_valid_reg, out_valid_next;
    result_kind_t      kind_reg, kind_next;
    logic [BYTE_W-1:0] pbyte_reg, pbyte_next;
    logic [BYTE_W-1:0] pidx_reg, pidx_next;
    logic              with_fields;
    logic              eof_reg, eof_next;
    logic              has_result;

    // output register free or draining this cycle
    assign pop      = q_valid & (~out_valid_reg | m_ready);
    assign sum_add  = sum_reg + {{(SUM_W-BYTE_W){1'b0}}, head_cmd.data};
    assign received = {cks_hi_reg, head_cmd.data};

    always_comb begin
        sum_next    = sum_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        ctrl_next   = ctrl_reg;
        func_next   = func_reg;
        len_next    = len_reg;
        cks_hi_next = cks_hi_reg;
        has_result  = 1'b0;
        kind_next   = KIND_PAYLOAD;
        pbyte_next  = '0;
        pidx_next   = '0;
        with_fields = 1'b1;
        eof_next    = 1'b0;
        unique case (head_cmd.op)
            OP_HDR1: sum_next = {{(SUM_W-BYTE_W){1'b0}}, head_cmd.data};
            OP_HDR2: sum_next = sum_add;
            OP_BAD_HDR: begin
                sum_next    = '0;
                has_result  = 1'b1;
                kind_next   = KIND_BAD_HDR;
                with_fields = 1'b0;
                eof_next    = 1'b1;
            end
            OP_SRC_HI: begin
                sum_next = sum_add;
                src_next = {head_cmd.data, {BYTE_W{1'b0}}};
            end
            OP_SRC_LO: begin
                sum_next = sum_add;
                src_next = {src_reg[ADDR_W-1:BYTE_W], head_cmd.data};
            end
            OP_DST_HI: begin
                sum_next = sum_add;
                dst_next = {head_cmd.data, {BYTE_W{1'b0}}};
            end
            OP_DST_LO: begin
                sum_next = sum_add;
                dst_next = {dst_reg[ADDR_W-1:BYTE_W], head_cmd.data};
            end
            OP_CTRL: begin
                sum_next  = sum_add;
                ctrl_next = head_cmd.data;
            end
            OP_FUNC: begin
                sum_next  = sum_add;
                func_next = head_cmd.data;
            end
            OP_LEN: begin
                sum_next = sum_add;
                len_next = head_cmd.data;
            end
            OP_PAYLOAD: begin
                sum_next   = sum_add;
                has_result = 1'b1;
                pbyte_next = head_cmd.data;
                pidx_next  = head_cmd.index;
            end
            OP_CKS_HI: cks_hi_next = head_cmd.data;
            OP_CKS_LO: begin
                has_result = 1'b1;
                kind_next  = (received == sum_reg) ? KIND_OK : KIND_BAD_CKS;
                eof_next   = 1'b1;
            end
            default: ;
        endcase

        out_valid_next = out_valid_reg & ~m_ready;
        if (pop && has_result) begin
            out_valid_next = 1'b1;
        end
    end

    logic [ADDR_W-1:0] o_src_reg, o_dst_reg;
    logic [BYTE_W-1:0] o_ctrl_reg, o_func_reg, o_len_reg;
    logic [POS_W-1:0]  o_flen_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            sum_reg    <= sum_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            ctrl_reg   <= ctrl_next;
            func_reg   <= func_next;
            len_reg    <= len_next;
            cks_hi_reg <= cks_hi_next;
        end
        if (pop && has_result) begin
            kind_reg   <= kind_next;
            pbyte_reg  <= pbyte_next;
            pidx_reg   <= pidx_next;
            eof_reg    <= eof_next;
            o_src_reg  <= with_fields ? src_reg  : '0;
            o_dst_reg  <= with_fields ? dst_reg  : '0;
            o_ctrl_reg <= with_fields ? ctrl_reg : '0;
            o_func_reg <= with_fields ? func_reg : '0;
            o_len_reg  <= with_fields ? len_reg  : '0;
            o_flen_reg <= with_fields ? FRAME_OVERHEAD + {1'b0, len_reg} : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_result_kind         = kind_reg;
    assign m_payload_byte        = pbyte_reg;
    assign m_payload_index       = pidx_reg;
    assign m_source_address      = o_src_reg;
    assign m_destination_address = o_dst_reg;
    assign m_control_code        = o_ctrl_reg;
    assign m_function_code       = o_func_reg;
    assign m_payload_length      = o_len_reg;
    assign m_frame_length        = o_flen_reg;
    assign m_end_of_frame        = eof_reg;

endmodule

// ----- rtl/sum16_frame_parser.sv -----
// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------
// input    | s_valid / s_ready  | s_rx_byte
// result   | m_valid / m_ready  | m_result_kind .. m_end_of_frame (10 fields)
// config   | cfg_wr_en          | cfg_index, cfg_wdata
//
// One byte per cycle sustained while m_ready stays high. A byte is classified
// by the front end at the transfer edge and written into the queue; the back
// end sums and resolves it as it is popped and registers its result on m_valid.
// Reset clears frame position, queue, output valid and both header registers.
// With m_ready low the QUEUE_DEPTH-entry queue fills, then s_ready drops.
module sum16_frame_parser #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sfp_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [sfp_pkg::BYTE_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sfp_pkg::BYTE_W-1:0]     s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_result_kind,
    output logic [sfp_pkg::BYTE_W-1:0]     m_payload_byte,
    output logic [sfp_pkg::BYTE_W-1:0]     m_payload_index,
    output logic [sfp_pkg::ADDR_W-1:0]     m_source_address,
    output logic [sfp_pkg::ADDR_W-1:0]     m_destination_address,
    output logic [sfp_pkg::BYTE_W-1:0]     m_control_code,
    output logic [sfp_pkg::BYTE_W-1:0]     m_function_code,
    output logic [sfp_pkg::BYTE_W-1:0]     m_payload_length,
    output logic [sfp_pkg::POS_W-1:0]      m_frame_length,
    output logic                           m_end_of_frame
);
    import sfp_pkg::*;

    logic q_ready, q_valid, push, pop;
    cmd_t push_cmd, head_cmd;

    assign s_ready = q_ready;

    sfp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .q_ready   (q_ready),
        .s_rx_byte (s_rx_byte),
        .push      (push),
        .cmd       (push_cmd)
    );

    sfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_cmd (head_cmd)
    );

    sfp_back u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .q_valid               (q_valid),
        .head_cmd              (head_cmd),
        .pop                   (pop),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_result_kind         (m_result_kind),
        .m_payload_byte        (m_payload_byte),
        .m_payload_index       (m_payload_index),
        .m_source_address      (m_source_address),
        .m_destination_address (m_destination_address),
        .m_control_code        (m_control_code),
        .m_function_code       (m_function_code),
        .m_payload_length      (m_payload_length),
        .m_frame_length        (m_frame_length),
        .m_end_of_frame        (m_end_of_frame)
    );

endmodule
